/* hw/rtl/xsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package xsf_pkg;

	localparam int XSF_SPRITE_BITS = 8;
	localparam int XSF_ROW_BITS    = 64;
	localparam logic [XSF_SPRITE_BITS-1:0] XSF_SPRITE_MSB = 8'h80;

	typedef enum logic [1:0] {
		XSF_CLEAR = 2'd0,
		XSF_DRAW  = 2'd1,
		XSF_READ  = 2'd2
	} xsf_action_t;

	typedef enum logic {
		XSF_RES_DRAW = 1'b0,
		XSF_RES_READ = 1'b1
	} xsf_kind_t;

	typedef struct packed {
		xsf_action_t                action;
		logic [XSF_SPRITE_BITS-1:0] sprite_byte;
		logic [7:0]                 x_pos;
		logic [7:0]                 y_pos;
		logic [3:0]                 row_index;
		logic                       last_row;
	} xsf_req_t;

	typedef struct packed {
		logic                    collision;
		logic [XSF_ROW_BITS-1:0] row_pixels;
		xsf_kind_t               result_kind;
	} xsf_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/xsf_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface xsf_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/xor_sprite_framebuffer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Monochrome framebuffer of SCREEN_HEIGHT rows by SCREEN_WIDTH columns with
// sprite drawing by XOR. Each req item is one action: clear the screen, draw
// one sprite byte (bit 7 leftmost) at column x_pos and row y_pos + row_index,
// both wrapping around the screen, or read the row y_pos. A draw item marked
// last_row returns one rsp item whose collision bit is set if any pixel of the
// sprite turned off; a read item returns the row with column c in bit c of
// row_pixels. Clear items and unused action codes return nothing. The block
// takes one item per cycle: stage 0 looks up the wrapped row and column and
// issues the RAM read, stage 1 does the read-modify-write of that one row,
// with the row written in the cycle before forwarded to the next item. The
// only thing that holds req.ready low is an item in stage 1 that owes a result
// while the rsp register is still full and not taken. A result passes through
// the stage 1 registers and then the rsp register. Reset and clear items mark
// every row empty through one valid flip-flop per row, so no sweep of the RAM
// is needed.
module xor_sprite_framebuffer #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	xsf_stream_if.sink   req,
	xsf_stream_if.source rsp
);

	import xsf_pkg::*;

	localparam int XW         = $clog2(SCREEN_WIDTH);
	localparam int AW         = $clog2(SCREEN_HEIGHT);
	// Wrapped base row (below SCREEN_HEIGHT) plus row_index (below 16) fits in 7 bits for SCREEN_HEIGHT up to 112.
	localparam int YSUM_W     = 7;
	localparam int YSUM_DEPTH = 2 ** YSUM_W;
	localparam int COORD_DEPTH = 256;

	// Constant wrap tables for the 8-bit coordinates and the row sum.
	logic [XW-1:0] x_mod_tab  [COORD_DEPTH];
	logic [AW-1:0] y_mod_tab  [COORD_DEPTH];
	logic [AW-1:0] y_wrap_tab [YSUM_DEPTH];

	for (genvar i = 0; i < COORD_DEPTH; i++) begin : g_coord_tab
		assign x_mod_tab[i] = XW'(i % SCREEN_WIDTH);
		assign y_mod_tab[i] = AW'(i % SCREEN_HEIGHT);
	end

	for (genvar i = 0; i < YSUM_DEPTH; i++) begin : g_wrap_tab
		assign y_wrap_tab[i] = AW'(i % SCREEN_HEIGHT);
	end

	// Stage 0: wrap coordinates, build the column mask, address the RAM.
	logic [XW-1:0]           x_base;
	logic [YSUM_W-1:0]       y_sum;
	logic [AW-1:0]           row_s0;
	logic [SCREEN_WIDTH-1:0] mask_s0;
	logic [XW:0]             col_sum;

	always_comb begin
		x_base  = x_mod_tab[req.data.x_pos];
		y_sum   = YSUM_W'(y_mod_tab[req.data.y_pos]) + YSUM_W'(req.data.row_index);
		row_s0  = (req.data.action == XSF_DRAW) ? y_wrap_tab[y_sum] : y_mod_tab[req.data.y_pos];
		mask_s0 = '0;
		col_sum = '0;
		// The user must keep the screen at least eight columns wide; the block does
		// not enforce it. Then the eight columns are distinct and each one wraps at most once.
		for (int b = 0; b < XSF_SPRITE_BITS; b++) begin
			col_sum = {1'b0, x_base} + (XW+1)'(b);
			if (col_sum >= (XW+1)'(SCREEN_WIDTH)) begin
				col_sum = col_sum - (XW+1)'(SCREEN_WIDTH);
			end
			if ((req.data.sprite_byte & (XSF_SPRITE_MSB >> b)) != '0) begin
				mask_s0[col_sum[XW-1:0]] = 1'b1;
			end
		end
	end

	// Stage 1 registers.
	logic                    valid_s1;
	xsf_action_t             action_s1;
	logic [AW-1:0]           row_s1;
	logic [SCREEN_WIDTH-1:0] mask_s1;
	logic                    last_s1;

	// Row store state and forwarding of the last written row.
	logic [SCREEN_HEIGHT-1:0] row_valid_q;
	logic                     fwd_valid_q;
	logic [AW-1:0]            fwd_row_q;
	logic [SCREEN_WIDTH-1:0]  fwd_data_q;
	logic                     collision_acc_q;

	logic                     rsp_valid_q;
	xsf_rsp_t                 rsp_data_q;

	logic                    needs_rsp_s1;
	logic                    s1_free;
	logic                    accept;
	logic                    retire;
	logic                    is_draw_s1;
	logic                    is_read_s1;
	logic                    is_clear_s1;
	logic                    wr_en;
	logic [SCREEN_WIDTH-1:0] rd_data;
	logic [SCREEN_WIDTH-1:0] old_row;
	logic [SCREEN_WIDTH-1:0] new_row;
	logic                    hit;

	always_comb begin
		is_draw_s1  = 1'b0;
		is_read_s1  = 1'b0;
		is_clear_s1 = 1'b0;
		unique case (action_s1)
			XSF_CLEAR: is_clear_s1 = 1'b1;
			XSF_DRAW:  is_draw_s1  = 1'b1;
			XSF_READ:  is_read_s1  = 1'b1;
			default:   ;  // unused action code: drop the item
		endcase
	end

	// Hold stage 1 only while it owes a result and the rsp register is stuck.
	assign needs_rsp_s1 = valid_s1 && ((is_draw_s1 && last_s1) || is_read_s1);
	assign s1_free      = !needs_rsp_s1 || !rsp_valid_q || rsp.ready;
	assign req.ready    = s1_free;
	assign accept       = req.valid && s1_free;
	assign retire       = valid_s1 && s1_free;
	assign wr_en        = retire && is_draw_s1;

	xsf_ram #(
		.WIDTH (SCREEN_WIDTH),
		.DEPTH (SCREEN_HEIGHT)
	) u_rows (
		.clk   (clk),
		.we    (wr_en),
		.waddr (row_s1),
		.wdata (new_row),
		.re    (accept),
		.raddr (row_s0),
		.rdata (rd_data)
	);

	// The RAM read missed the write made at the edge this item entered
	// stage 1; take that row from the forwarding register instead.
	always_comb begin
		if (fwd_valid_q && (fwd_row_q == row_s1)) begin
			old_row = fwd_data_q;
		end else if (row_valid_q[row_s1]) begin
			old_row = rd_data;
		end else begin
			old_row = '0;
		end
		new_row = old_row ^ mask_s1;
		hit     = |(old_row & mask_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= req.data.action;
			row_s1    <= row_s0;
			mask_s1   <= mask_s0;
			last_s1   <= req.data.last_row;
		end
	end

	// Freeze forwarding while stage 1 holds, so a held item keeps its view.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (s1_free) begin
			fwd_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			fwd_row_q  <= row_s1;
			fwd_data_q <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q     <= '0;
			collision_acc_q <= 1'b0;
		end else if (retire) begin
			if (is_clear_s1) begin
				row_valid_q <= '0;
			end
			if (is_draw_s1) begin
				row_valid_q[row_s1] <= 1'b1;
				collision_acc_q     <= last_s1 ? 1'b0 : (collision_acc_q | hit);
			end
		end
	end

	// Result register: load on a retiring item that owes a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (retire && needs_rsp_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && needs_rsp_s1) begin
			if (is_read_s1) begin
				rsp_data_q.collision   <= 1'b0;
				rsp_data_q.row_pixels  <= XSF_ROW_BITS'(old_row);
				rsp_data_q.result_kind <= XSF_RES_READ;
			end else begin
				rsp_data_q.collision   <= collision_acc_q | hit;
				rsp_data_q.row_pixels  <= '0;
				rsp_data_q.result_kind <= XSF_RES_DRAW;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

`default_nettype wire

/* hw/rtl/xsf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module xsf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old word when the same entry is written at the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/xsf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module xsf_checker #(
	parameter int SCREEN_WIDTH = 64
) (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input xsf_pkg::xsf_rsp_t rsp_data
);

	import xsf_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("rsp item changed while stalled");

	a_read_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.result_kind == XSF_RES_READ) |-> !rsp_data.collision)
		else $error("read item carries a collision");

	a_draw_no_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.result_kind == XSF_RES_DRAW) |-> (rsp_data.row_pixels == '0))
		else $error("draw item carries row pixels");

	a_row_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_data.row_pixels >> SCREEN_WIDTH) == '0))
		else $error("row pixels set beyond the screen width");

endmodule

bind xor_sprite_framebuffer xsf_checker #(
	.SCREEN_WIDTH (SCREEN_WIDTH)
) u_xsf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
